// ===== rtl/core/dda_line_pixel_generator_defines.svh =====
// assertion macros shared by the line pixel generator checkers
// expects aclk and aresetn in the scope where a macro is used
`ifndef DDA_LINE_PIXEL_GENERATOR_DEFINES_SVH
`define DDA_LINE_PIXEL_GENERATOR_DEFINES_SVH

// property checked only while out of reset
`define DLPG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// property that also covers the reset cycles
`define DLPG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/core/dlpg_pkg.sv =====
// shared types and constants of the line pixel generator
// no dependencies
`timescale 1ns / 1ps

package dlpg_pkg;

    // frame width register
    localparam int unsigned FRAME_W_BITS = 13;
    localparam logic [FRAME_W_BITS-1:0] FRAME_W_RESET = 13'd640;

    // byte address of a pixel, wraps at this width
    localparam int unsigned ADDR_BITS = 26;

    // one color component
    localparam int unsigned COMP_BITS = 8;

    // item kinds carried in s_tuser
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic [COMP_BITS-1:0] red;
        logic [COMP_BITS-1:0] green;
        logic [COMP_BITS-1:0] blue;
    } color_t;

endpackage

// ===== rtl/core/dlpg_in_stage.sv =====
// input register stage of the line pixel generator
// depends on dlpg_pkg
`timescale 1ns / 1ps

module dlpg_in_stage #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // upstream side
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_mode,
    input  logic [COORD_BITS-1:0] in_sx,
    input  logic [COORD_BITS-1:0] in_sy,
    input  logic [COORD_BITS-1:0] in_ex,
    input  logic [COORD_BITS-1:0] in_ey,
    input  dlpg_pkg::color_t      in_color,
    // toward the step unit
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_mode,
    output logic [COORD_BITS-1:0] out_sx,
    output logic [COORD_BITS-1:0] out_sy,
    output logic [COORD_BITS-1:0] out_ex,
    output logic [COORD_BITS-1:0] out_ey,
    output dlpg_pkg::color_t      out_color
);

    logic                  valid_reg;
    logic                  mode_reg;
    logic [COORD_BITS-1:0] sx_reg;
    logic [COORD_BITS-1:0] sy_reg;
    logic [COORD_BITS-1:0] ex_reg;
    logic [COORD_BITS-1:0] ey_reg;
    dlpg_pkg::color_t      color_reg;

    // register can load when empty or drained this cycle
    assign in_ready = !valid_reg || out_ready;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // item payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            mode_reg  <= in_mode;
            sx_reg    <= in_sx;
            sy_reg    <= in_sy;
            ex_reg    <= in_ex;
            ey_reg    <= in_ey;
            color_reg <= in_color;
        end
    end

    assign out_valid = valid_reg;
    assign out_mode  = mode_reg;
    assign out_sx    = sx_reg;
    assign out_sy    = sy_reg;
    assign out_ex    = ex_reg;
    assign out_ey    = ey_reg;
    assign out_color = color_reg;

endmodule

// ===== rtl/core/dlpg_step.sv =====
// line state and one dda step per tick, registered pixel coordinates
// depends on dlpg_pkg
`timescale 1ns / 1ps

module dlpg_step #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // items from the input register
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic                  item_mode,
    input  logic [COORD_BITS-1:0] item_sx,
    input  logic [COORD_BITS-1:0] item_sy,
    input  logic [COORD_BITS-1:0] item_ex,
    input  logic [COORD_BITS-1:0] item_ey,
    input  dlpg_pkg::color_t      item_color,
    // pixels toward the address stage
    output logic                  pix_valid,
    input  logic                  pix_ready,
    output logic [COORD_BITS-1:0] pix_x,
    output logic [COORD_BITS-1:0] pix_y,
    output dlpg_pkg::color_t      pix_color,
    output logic                  pix_last
);

    localparam int unsigned CB = COORD_BITS;
    localparam int unsigned RB = COORD_BITS + 1;

    // line state
    logic          active_reg,  active_next;
    logic [CB-1:0] cur_x_reg,   cur_x_next;
    logic [CB-1:0] cur_y_reg,   cur_y_next;
    logic [CB-1:0] abs_dx_reg,  abs_dx_next;
    logic [CB-1:0] abs_dy_reg,  abs_dy_next;
    logic          neg_x_reg,   neg_x_next;
    logic          neg_y_reg,   neg_y_next;
    logic [RB-1:0] rem_x_reg,   rem_x_next;
    logic [RB-1:0] rem_y_reg,   rem_y_next;
    logic [CB-1:0] step_reg,    step_next;
    logic [CB-1:0] index_reg,   index_next;
    dlpg_pkg::color_t color_reg, color_next;

    // pixel register
    logic          pix_valid_reg;
    logic [CB-1:0] pix_x_reg;
    logic [CB-1:0] pix_y_reg;
    dlpg_pkg::color_t pix_color_reg;
    logic          pix_last_reg;

    logic          adv;
    logic          take;
    logic          emit;
    logic          ld_neg_x;
    logic          ld_neg_y;
    logic [CB-1:0] ld_abs_dx;
    logic [CB-1:0] ld_abs_dy;
    logic [CB-1:0] ld_step;
    logic [CB-1:0] px;
    logic [CB-1:0] py;
    logic [RB-1:0] sum_x;
    logic [RB-1:0] sum_y;
    logic          carry_x;
    logic          carry_y;
    logic          last;

    // one item taken whenever the pixel register can load
    assign adv        = !pix_valid_reg || pix_ready;
    assign item_ready = adv;
    assign take       = item_valid && adv;
    assign emit       = take && (item_mode == dlpg_pkg::MODE_TICK) && active_reg;

    // deltas of a new line
    always_comb begin
        ld_neg_x  = item_ex < item_sx;
        ld_neg_y  = item_ey < item_sy;
        ld_abs_dx = ld_neg_x ? (item_sx - item_ex) : (item_ex - item_sx);
        ld_abs_dy = ld_neg_y ? (item_sy - item_ey) : (item_ey - item_sy);
        ld_step   = (ld_abs_dx > ld_abs_dy) ? ld_abs_dx : ld_abs_dy;
    end

    // current pixel: step back one where a negative axis has a remainder
    assign px = (neg_x_reg && (rem_x_reg != '0)) ? (cur_x_reg - 1'b1) : cur_x_reg;
    assign py = (neg_y_reg && (rem_y_reg != '0)) ? (cur_y_reg - 1'b1) : cur_y_reg;

    // remainder advance per axis
    assign sum_x   = rem_x_reg + {1'b0, abs_dx_reg};
    assign sum_y   = rem_y_reg + {1'b0, abs_dy_reg};
    assign carry_x = sum_x >= {1'b0, step_reg};
    assign carry_y = sum_y >= {1'b0, step_reg};
    assign last    = ({1'b0, index_reg} + 1'b1) >= {1'b0, step_reg};

    // next line state
    always_comb begin
        active_next = active_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        abs_dx_next = abs_dx_reg;
        abs_dy_next = abs_dy_reg;
        neg_x_next  = neg_x_reg;
        neg_y_next  = neg_y_reg;
        rem_x_next  = rem_x_reg;
        rem_y_next  = rem_y_reg;
        step_next   = step_reg;
        index_next  = index_reg;
        color_next  = color_reg;
        if (take && (item_mode == dlpg_pkg::MODE_LOAD)) begin
            active_next = ld_step != '0;
            cur_x_next  = item_sx;
            cur_y_next  = item_sy;
            abs_dx_next = ld_abs_dx;
            abs_dy_next = ld_abs_dy;
            neg_x_next  = ld_neg_x;
            neg_y_next  = ld_neg_y;
            rem_x_next  = '0;
            rem_y_next  = '0;
            step_next   = ld_step;
            index_next  = '0;
            color_next  = item_color;
        end else if (emit) begin
            rem_x_next = carry_x ? (sum_x - {1'b0, step_reg}) : sum_x;
            rem_y_next = carry_y ? (sum_y - {1'b0, step_reg}) : sum_y;
            if (carry_x) begin
                cur_x_next = neg_x_reg ? (cur_x_reg - 1'b1) : (cur_x_reg + 1'b1);
            end
            if (carry_y) begin
                cur_y_next = neg_y_reg ? (cur_y_reg - 1'b1) : (cur_y_reg + 1'b1);
            end
            index_next = index_reg + 1'b1;
            if (last) begin
                active_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            pix_valid_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            if (adv) begin
                pix_valid_reg <= emit;
            end
        end
    end

    // line payload state
    always_ff @(posedge aclk) begin
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        abs_dx_reg <= abs_dx_next;
        abs_dy_reg <= abs_dy_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        rem_x_reg  <= rem_x_next;
        rem_y_reg  <= rem_y_next;
        step_reg   <= step_next;
        index_reg  <= index_next;
        color_reg  <= color_next;
    end

    // pixel payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            pix_x_reg     <= px;
            pix_y_reg     <= py;
            pix_color_reg <= color_reg;
            pix_last_reg  <= last;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix_x     = pix_x_reg;
    assign pix_y     = pix_y_reg;
    assign pix_color = pix_color_reg;
    assign pix_last  = pix_last_reg;

endmodule

// ===== rtl/core/dlpg_addr.sv =====
// byte address 3*(x + width*y) and the result register
// depends on dlpg_pkg
`timescale 1ns / 1ps

module dlpg_addr #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [dlpg_pkg::FRAME_W_BITS-1:0]   frame_width,
    // pixels from the step unit
    input  logic                                pix_valid,
    output logic                                pix_ready,
    input  logic [COORD_BITS-1:0]               pix_x,
    input  logic [COORD_BITS-1:0]               pix_y,
    input  dlpg_pkg::color_t                    pix_color,
    input  logic                                pix_last,
    // result side
    output logic                                res_valid,
    input  logic                                res_ready,
    output logic [COORD_BITS-1:0]               res_x,
    output logic [COORD_BITS-1:0]               res_y,
    output logic [dlpg_pkg::ADDR_BITS-1:0]      res_addr,
    output dlpg_pkg::color_t                    res_color,
    output logic                                res_last
);

    localparam int unsigned AW = dlpg_pkg::ADDR_BITS;
    localparam int unsigned PW = dlpg_pkg::FRAME_W_BITS + COORD_BITS;

    logic                  valid_reg;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic [AW-1:0]         addr_reg;
    dlpg_pkg::color_t      color_reg;
    logic                  last_reg;

    logic [PW-1:0] row_prod;
    logic [AW-1:0] lin;
    logic [AW-1:0] addr;

    // linear pixel index, then times three as shift and add
    assign row_prod = PW'(frame_width) * PW'(pix_y);
    assign lin      = AW'(row_prod) + AW'(pix_x);
    assign addr     = {lin[AW-2:0], 1'b0} + lin;

    assign pix_ready = !valid_reg || res_ready;

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pix_ready) begin
            valid_reg <= pix_valid;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (pix_ready && pix_valid) begin
            x_reg     <= pix_x;
            y_reg     <= pix_y;
            addr_reg  <= addr;
            color_reg <= pix_color;
            last_reg  <= pix_last;
        end
    end

    assign res_valid = valid_reg;
    assign res_x     = x_reg;
    assign res_y     = y_reg;
    assign res_addr  = addr_reg;
    assign res_color = color_reg;
    assign res_last  = last_reg;

endmodule

// ===== rtl/core/dda_line_pixel_generator.sv =====
// top level of the dda line pixel generator
// depends on dlpg_pkg, dlpg_in_stage, dlpg_step, dlpg_addr
`timescale 1ns / 1ps
//
//  channel  | ports                           | moves
//  ---------+---------------------------------+------------------------------------
//  input    | s_tvalid s_tready s_tuser s_tdata | load line (tuser 0) or tick (tuser 1)
//  result   | m_tvalid m_tready m_tlast m_tdata | one pixel, tlast on the final one
//  config   | cfg_valid cfg_ready cfg_data    | frame width, pixels per row
//
//  one item per clock while m_tready is high; a pixel leaves through three registers after its tick is taken
//  (input register, dda step register, address/result register)
//  aresetn is synchronous: clears the line active flag and all valid flags, width back to 640
//  a stall on m_tready backs up through the three registers to s_tready
//  loads and idle ticks pass through the pipe and leave no result

module dda_line_pixel_generator #(
    parameter int unsigned COORD_BITS = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // fields low to high: start_x, start_y, end_x, end_y, red_in, green_in, blue_in
    input  logic [((4*COORD_BITS+3*dlpg_pkg::COMP_BITS+7)/8)*8-1:0] s_tdata,
    // fields: mode
    input  logic [0:0]                          s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // fields low to high: pixel_x, pixel_y, byte_address, red_out, green_out, blue_out
    output logic [((2*COORD_BITS+dlpg_pkg::ADDR_BITS+3*dlpg_pkg::COMP_BITS+7)/8)*8-1:0]
                                                m_tdata,
    // last_pixel
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // frame width register write
    input  logic [dlpg_pkg::FRAME_W_BITS-1:0]   cfg_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready
);

    localparam int unsigned CB = COORD_BITS;
    localparam int unsigned KB = dlpg_pkg::COMP_BITS;
    localparam int unsigned AW = dlpg_pkg::ADDR_BITS;
    localparam int unsigned MW = ((2*CB + AW + 3*KB + 7) / 8) * 8;

    logic [dlpg_pkg::FRAME_W_BITS-1:0] frame_width_reg;

    dlpg_pkg::color_t s_color;
    logic             item_valid, item_ready, item_mode;
    logic [CB-1:0]    item_sx, item_sy, item_ex, item_ey;
    dlpg_pkg::color_t item_color;
    logic             pix_valid, pix_ready, pix_last;
    logic [CB-1:0]    pix_x, pix_y;
    dlpg_pkg::color_t pix_color;
    logic [CB-1:0]    res_x, res_y;
    logic [AW-1:0]    res_addr;
    dlpg_pkg::color_t res_color;

    // frame width register, always ready for a transfer
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg <= dlpg_pkg::FRAME_W_RESET;
        end else if (cfg_valid && cfg_ready) begin
            frame_width_reg <= cfg_data;
        end
    end

    // color fields of the input transfer
    assign s_color.red   = s_tdata[4*CB +: KB];
    assign s_color.green = s_tdata[4*CB+KB +: KB];
    assign s_color.blue  = s_tdata[4*CB+2*KB +: KB];

    dlpg_in_stage #(.COORD_BITS(CB)) u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser[0]),
        .in_sx     (s_tdata[0 +: CB]),
        .in_sy     (s_tdata[CB +: CB]),
        .in_ex     (s_tdata[2*CB +: CB]),
        .in_ey     (s_tdata[3*CB +: CB]),
        .in_color  (s_color),
        .out_valid (item_valid),
        .out_ready (item_ready),
        .out_mode  (item_mode),
        .out_sx    (item_sx),
        .out_sy    (item_sy),
        .out_ex    (item_ex),
        .out_ey    (item_ey),
        .out_color (item_color)
    );

    dlpg_step #(.COORD_BITS(CB)) u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_mode  (item_mode),
        .item_sx    (item_sx),
        .item_sy    (item_sy),
        .item_ex    (item_ex),
        .item_ey    (item_ey),
        .item_color (item_color),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix_x      (pix_x),
        .pix_y      (pix_y),
        .pix_color  (pix_color),
        .pix_last   (pix_last)
    );

    dlpg_addr #(.COORD_BITS(CB)) u_addr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_width (frame_width_reg),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pix_x       (pix_x),
        .pix_y       (pix_y),
        .pix_color   (pix_color),
        .pix_last    (pix_last),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_x       (res_x),
        .res_y       (res_y),
        .res_addr    (res_addr),
        .res_color   (res_color),
        .res_last    (m_tlast)
    );

    // result fields, zero padded to whole bytes
    assign m_tdata = MW'({res_color.blue, res_color.green, res_color.red,
                          res_addr, res_y, res_x});

endmodule

// ===== rtl/core/dlpg_checker.sv =====
// port level checks of the line pixel generator, bound to the top level
// depends on dlpg_pkg and dda_line_pixel_generator_defines.svh
`timescale 1ns / 1ps
`include "dda_line_pixel_generator_defines.svh"

module dlpg_checker #(
    parameter int unsigned COORD_BITS = 12
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic [dlpg_pkg::FRAME_W_BITS-1:0]   cfg_data,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [((2*COORD_BITS+dlpg_pkg::ADDR_BITS+3*dlpg_pkg::COMP_BITS+7)/8)*8-1:0]
                                               m_tdata,
    input logic                                m_tlast,
    input logic                                m_tvalid,
    input logic                                m_tready
);

    localparam int unsigned CB = COORD_BITS;
    localparam int unsigned AW = dlpg_pkg::ADDR_BITS;
    localparam int unsigned PW = dlpg_pkg::FRAME_W_BITS + COORD_BITS;

    logic [dlpg_pkg::FRAME_W_BITS-1:0] width_reg;
    logic [CB-1:0] out_x;
    logic [CB-1:0] out_y;
    logic [AW-1:0] out_addr;
    logic [PW-1:0] exp_prod;
    logic [AW-1:0] exp_lin;
    logic [AW-1:0] exp_addr;
    logic          res_stall;
    logic [$bits(m_tdata):0] res_word;

    // shadow of the frame width as seen on the config port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= dlpg_pkg::FRAME_W_RESET;
        end else if (cfg_valid && cfg_ready) begin
            width_reg <= cfg_data;
        end
    end

    // expected address of the pixel on the result port
    assign out_x    = m_tdata[0 +: CB];
    assign out_y    = m_tdata[CB +: CB];
    assign out_addr = m_tdata[2*CB +: AW];
    assign exp_prod = PW'(width_reg) * PW'(out_y);
    assign exp_lin  = AW'(exp_prod) + AW'(out_x);
    assign exp_addr = {exp_lin[AW-2:0], 1'b0} + exp_lin;

    // result waiting on the receiver, and everything it shows
    assign res_stall = m_tvalid && !m_tready;
    assign res_word  = {m_tlast, m_tdata};

    // no result straight out of reset
    `DLPG_ASSERT_ALWAYS(a_reset_clears_result, !aresetn |=> !m_tvalid, "result valid after reset")

    // the address matches the shown pixel and the current width
    `DLPG_ASSERT(a_addr_matches, m_tvalid |-> (out_addr == exp_addr), "byte address mismatch")

    // a stalled result holds
    `DLPG_ASSERT(a_result_holds, res_stall |=> (m_tvalid && $stable(res_word)), "stalled result changed")

endmodule

bind dda_line_pixel_generator dlpg_checker #(.COORD_BITS(COORD_BITS)) u_dlpg_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready)
);
